FILE: src/bcl_pkg.sv
// Shared types and codes for the bounded circular list.
// Holds op codes, status codes and the cell move codes; no dependencies.
package bcl_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [VALUE_W-1:0]  word_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_FIND       = 3'd4;
    localparam op_t OP_REMOVE     = 3'd5;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    typedef logic [2:0] cell_mode_t;

    localparam cell_mode_t CM_HOLD    = 3'd0;
    localparam cell_mode_t CM_SHR     = 3'd1;
    localparam cell_mode_t CM_ROTL    = 3'd2;
    localparam cell_mode_t CM_WRITE   = 3'd3;
    localparam cell_mode_t CM_COMPACT = 3'd4;

endpackage

FILE: src/bcl_cell.sv
// One storage cell of the list row: holds the entry at a fixed logical position.
// Depends on bcl_pkg for the move codes.
module bcl_cell #(
    parameter int DEPTH = bcl_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                     clk,
    input  bcl_pkg::cell_mode_t      mode,
    input  logic [$clog2(DEPTH)-1:0] pos,
    input  bcl_pkg::word_t           prev_data,
    input  bcl_pkg::word_t           next_data,
    input  bcl_pkg::word_t           load_data,
    output bcl_pkg::word_t           data
);
    import bcl_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (mode)
            CM_SHR:
            begin
                data_next = prev_data;
            end
            CM_ROTL:
            begin
                data_next = next_data;
            end
            CM_WRITE:
            begin
                if (pos == MY_IDX)
                begin
                    data_next = load_data;
                end
            end
            CM_COMPACT:
            begin
                if (MY_IDX >= pos)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: src/bcl_ctrl.sv
// Sequencer of the list: decodes requests, runs the search over the row,
// keeps the fill count and holds the result beat. Depends on bcl_pkg.
module bcl_ctrl #(
    parameter int DEPTH = bcl_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bcl_pkg::op_t                  op,
    input  bcl_pkg::word_t                value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bcl_pkg::status_t              status,
    output logic [bcl_pkg::POS_W-1:0]     position,
    output logic [bcl_pkg::COUNT_W-1:0]   count,
    input  bcl_pkg::word_t                head_data,
    output bcl_pkg::cell_mode_t           cell_mode,
    output logic [$clog2(DEPTH)-1:0]      cell_pos
);
    import bcl_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;
    localparam logic [1:0] S_DONE    = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CNTW-1:0] fill_reg, fill_next;
    logic [IDXW-1:0] step_reg, step_next;
    logic [IDXW-1:0] fpos_reg, fpos_next;
    logic            found_reg, found_next;
    logic            remove_reg, remove_next;
    word_t           key_reg, key_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic    slot_free;
    logic    accept;
    logic    full;
    logic    empty;
    logic    match_now;
    logic    res_we;
    status_t res_status;
    logic [IDXW-1:0] res_pos;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && slot_free);
    assign accept    = in_valid && !in_stall;
    assign full      = (fill_reg == CNTW'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign match_now = (head_data == key_reg) && (CNTW'(step_reg) < fill_reg);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        step_next   = step_reg;
        fpos_next   = fpos_reg;
        found_next  = found_reg;
        remove_next = remove_reg;
        key_next    = key_reg;
        cell_mode   = CM_HOLD;
        cell_pos    = '0;
        res_we      = 1'b0;
        res_status  = ST_OK;
        res_pos     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_we = 1'b1;
                    case (op)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                cell_mode = CM_SHR;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                cell_mode = CM_WRITE;
                                cell_pos  = fill_reg[IDXW-1:0];
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cell_mode = CM_ROTL;
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_FIND, OP_REMOVE:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                res_we      = 1'b0;
                                key_next    = value;
                                remove_next = (op == OP_REMOVE);
                                step_next   = '0;
                                found_next  = 1'b0;
                                fpos_next   = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cell_mode = CM_ROTL;
                if (match_now && !found_reg)
                begin
                    found_next = 1'b1;
                    fpos_next  = step_reg;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == IDXW'(DEPTH - 1))
                begin
                    if (remove_reg && (found_reg || match_now))
                    begin
                        state_next = S_COMPACT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_COMPACT:
            begin
                cell_mode  = CM_COMPACT;
                cell_pos   = fpos_reg;
                fill_next  = fill_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_we     = 1'b1;
                    res_status = found_reg ? ST_OK : ST_NOTFOUND;
                    res_pos    = (found_reg && !remove_reg) ? fpos_reg : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        position_next  = position_reg;
        count_next     = count_reg;
        if (res_we)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status;
            position_next  = POS_W'(res_pos);
            count_next     = COUNT_W'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            remove_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            remove_reg    <= remove_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fpos_reg     <= fpos_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        position_reg <= position_next;
        count_reg    <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign position  = position_reg;
    assign count     = count_reg;

endmodule

FILE: src/bounded_circular_list.sv
// Top level of the bounded circular list: a row of DEPTH cells in list order
// plus the sequencer. Depends on bcl_pkg, bcl_cell and bcl_ctrl.
//
//   beat     signals                    payload
//   request  in_valid / in_stall        op, value
//   result   out_valid / out_stall      status, position, count
//
// Push, pop and unused ops finish at the edge that takes the request.
// Find rotates the whole row once through cell 0, one cell per step, and then
// posts the result from the done state. A remove that finds its value first
// spends a compact step closing the gap before it posts from the done state.
// Reset empties the list; cell contents are not cleared. One request is in flight;
// a held result stays put and the next request is taken once that slot frees.
module bounded_circular_list #(
    parameter int DEPTH = bcl_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bcl_pkg::op_t                       op,
    input  logic signed [bcl_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bcl_pkg::status_t                   status,
    output logic [bcl_pkg::POS_W-1:0]          position,
    output logic [bcl_pkg::COUNT_W-1:0]        count
);
    import bcl_pkg::*;

    localparam int IDXW = $clog2(DEPTH);

    word_t           cell_data [DEPTH];
    cell_mode_t      cell_mode;
    logic [IDXW-1:0] cell_pos;
    word_t           value_w;

    assign value_w = word_t'(value);

    bcl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value_w),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .position  (position),
        .count     (count),
        .head_data (cell_data[0]),
        .cell_mode (cell_mode),
        .cell_pos  (cell_pos)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bcl_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .mode      (cell_mode),
            .pos       (cell_pos),
            .prev_data ((i == 0) ? value_w : cell_data[(i + DEPTH - 1) % DEPTH]),
            .next_data (cell_data[(i + 1) % DEPTH]),
            .load_data (value_w),
            .data      (cell_data[i])
        );
    end

endmodule

FILE: src/bcl_checker.sv
// Port-level checks for the bounded circular list, bound to the top level.
// Depends on bcl_pkg for the status codes.
module bcl_checker #(
    parameter int DEPTH = bcl_pkg::DEPTH_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input bcl_pkg::status_t                   status,
    input logic [bcl_pkg::POS_W-1:0]          position,
    input logic [bcl_pkg::COUNT_W-1:0]        count
);
    import bcl_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall))
        else $error("unknown stall on an offered request beat");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (count == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (count == FULL_COUNT))
        else $error("full status with count below depth");

    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position != '0) |-> (status == ST_OK))
        else $error("nonzero position on a failed request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(status) && $stable(position) && $stable(count)))
        else $error("stalled result beat changed");

endmodule

bind bounded_circular_list bcl_checker #(.DEPTH(DEPTH)) u_bcl_checker (.*);
